// ===== sv/attribute_subscription_table_defines.svh =====
// Assertion macros shared by the RTL.
// Each expects i_clk and i_rst_n in scope.
`ifndef ATTRIBUTE_SUBSCRIPTION_TABLE_DEFINES_SVH
`define ATTRIBUTE_SUBSCRIPTION_TABLE_DEFINES_SVH

// Same-cycle implication.
`define AST_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define AST_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ast_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ast_pkg;

    localparam int SLOTS = 16;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int ID_W  = 9;

    localparam logic [ID_W-1:0] ID_BASE = ID_W'(256);

    localparam logic [1:0] MODE_SUB    = 2'd0;
    localparam logic [1:0] MODE_ONCE   = 2'd1;
    localparam logic [1:0] MODE_CHANGE = 2'd2;

    typedef enum logic [1:0] {
        ST_STORED = 2'd0,
        ST_FULL   = 2'd1,
        ST_NOTIFY = 2'd2,
        ST_NONE   = 2'd3
    } t_status;

    typedef struct packed {
        logic [15:0] key;
        logic [15:0] handler;
        logic        one_shot;
    } t_entry;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] attr_id;
        logic [15:0] txn_id;
        logic [15:0] handler;
        logic [7:0]  encoding;
        logic [15:0] payload_ref;
        logic [15:0] payload_size;
    } t_item;

    typedef struct packed {
        t_status         status;
        logic [ID_W-1:0] subscription_id;
        logic [15:0]     notify_handler;
        logic [15:0]     notify_attr;
        logic [15:0]     notify_trans;
        logic [7:0]      notify_encoding;
        logic [15:0]     notify_ref;
        logic [15:0]     notify_size;
        logic            expired;
    } t_result;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
        logic [IDX_W-1:0] raddr;
    } t_store_req;

    typedef struct packed {
        logic             idle;
        logic [CNT_W-1:0] count;
    } t_ctrl_stat;

endpackage

`default_nettype wire

// ===== sv/ast_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Slot memory: one write port, one registered read port.
module ast_store (
    input  wire               i_clk,
    input  ast_pkg::t_store_req i_req,
    output ast_pkg::t_entry   o_rdata
);
    import ast_pkg::*;

    t_entry r_mem [SLOTS];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/ast_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Sequencer: linear key search, insert/overwrite, one-shot removal.
module ast_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_take,
    input  ast_pkg::t_item      i_item,
    output ast_pkg::t_ctrl_stat o_stat,
    output logic                o_res_valid,
    output ast_pkg::t_result    o_res,
    input  wire                 i_res_take,
    output ast_pkg::t_store_req o_req,
    input  ast_pkg::t_entry     i_rdata
);
    import ast_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_SEARCH  = 5'b00010,
        S_MOVE_RD = 5'b00100,
        S_MOVE_WR = 5'b01000,
        S_RESULT  = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    t_item            r_item,  n_item;
    logic [CNT_W-1:0] r_idx,   n_idx;
    logic             r_pend,  n_pend;
    logic [IDX_W-1:0] r_pidx,  n_pidx;
    logic [CNT_W-1:0] r_count, n_count;
    t_result          r_res,   n_res;

    logic             w_hit;
    logic             w_change;
    logic [CNT_W-1:0] w_last;

    assign w_change = (r_item.mode == MODE_CHANGE);
    assign w_hit    = r_pend && (i_rdata.key == r_item.attr_id);
    assign w_last   = r_count - CNT_W'(1);

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_pidx      = r_pidx;
        n_count     = r_count;
        n_res       = r_res;
        o_res_valid = 1'b0;
        o_req.we    = 1'b0;
        o_req.waddr = r_pidx;
        o_req.wdata = i_rdata;
        o_req.raddr = r_idx[IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_take) begin
                    n_item = i_item;
                    n_idx  = '0;
                    n_pend = 1'b0;
                    n_res  = '0;
                    if (i_item.mode == MODE_SUB || i_item.mode == MODE_ONCE ||
                        i_item.mode == MODE_CHANGE) begin
                        n_state = S_SEARCH;
                    end else begin
                        n_res.status = ST_NONE;
                        n_state      = S_RESULT;
                    end
                end
            end
            S_SEARCH: begin
                if (w_hit) begin
                    if (w_change) begin
                        n_res.status          = ST_NOTIFY;
                        n_res.notify_handler  = i_rdata.handler;
                        n_res.notify_attr     = r_item.attr_id;
                        n_res.notify_trans    = r_item.txn_id;
                        n_res.notify_encoding = r_item.encoding;
                        n_res.notify_ref      = r_item.payload_ref;
                        n_res.notify_size     = r_item.payload_size;
                        if (i_rdata.one_shot) begin
                            n_res.expired = 1'b1;
                            n_state       = S_MOVE_RD;
                        end else begin
                            n_state = S_RESULT;
                        end
                    end else begin
                        // existing key: overwrite handler and kind
                        o_req.we             = 1'b1;
                        o_req.waddr          = r_pidx;
                        o_req.wdata.key      = r_item.attr_id;
                        o_req.wdata.handler  = r_item.handler;
                        o_req.wdata.one_shot = (r_item.mode == MODE_ONCE);
                        n_res.status          = ST_STORED;
                        n_res.subscription_id = ID_BASE + ID_W'(r_pidx);
                        n_state               = S_RESULT;
                    end
                end else if (r_idx < r_count) begin
                    n_pend = 1'b1;
                    n_pidx = r_idx[IDX_W-1:0];
                    n_idx  = r_idx + CNT_W'(1);
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_RESULT;
                    if (w_change) begin
                        n_res.status = ST_NONE;
                    end else if (r_count == CNT_W'(SLOTS)) begin
                        n_res.status = ST_FULL;
                    end else begin
                        // append at the end of the valid region
                        o_req.we             = 1'b1;
                        o_req.waddr          = r_count[IDX_W-1:0];
                        o_req.wdata.key      = r_item.attr_id;
                        o_req.wdata.handler  = r_item.handler;
                        o_req.wdata.one_shot = (r_item.mode == MODE_ONCE);
                        n_count               = r_count + CNT_W'(1);
                        n_res.status          = ST_STORED;
                        n_res.subscription_id = ID_BASE + ID_W'(r_count[IDX_W-1:0]);
                    end
                end
            end
            S_MOVE_RD: begin
                o_req.raddr = w_last[IDX_W-1:0];
                n_state     = S_MOVE_WR;
            end
            S_MOVE_WR: begin
                // last entry into the freed slot (self-copy if it was last)
                o_req.we    = 1'b1;
                o_req.waddr = r_pidx;
                o_req.wdata = i_rdata;
                n_count     = w_last;
                n_state     = S_RESULT;
            end
            S_RESULT: begin
                o_res_valid = 1'b1;
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
        r_item <= n_item;
        r_idx  <= n_idx;
        r_pidx <= n_pidx;
        r_res  <= n_res;
    end

    assign o_res        = r_res;
    assign o_stat.idle  = (r_state == S_IDLE);
    assign o_stat.count = r_count;

endmodule

`default_nettype wire

// ===== sv/attribute_subscription_table.sv =====
// Attribute subscription table. Items arrive on a valid/ready input channel
// and each produces exactly one result on a valid/ready output channel.
// Mode 0 stores a persistent subscription, mode 1 a one-shot one (new key
// appended, existing key has handler and kind overwritten; id = 256 + slot,
// or status "full" with id 0). Mode 2 looks the attribute up and, on a hit,
// issues a notification; a one-shot entry is then removed by moving the
// last valid entry into its slot. Mode 3 answers "no subscriber". The slot
// memory has a single registered read port and one key is compared per
// cycle, so a search runs up to the hit or over all valid slots on a miss.
// One item is in work at a time; the result sits in an output register so
// the next item can be taken before it is drained. The slot memory needs
// no clearing: only slots below the valid count are read.
`timescale 1ns / 1ps
`default_nettype none

`include "attribute_subscription_table_defines.svh"

module attribute_subscription_table (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    // input channel
    input  wire                     i_valid,
    output logic                    o_ready,
    input  wire  [1:0]              i_mode,
    input  wire  [15:0]             i_attr_id,
    input  wire  [15:0]             i_txn_id,
    input  wire  [15:0]             i_handler,
    input  wire  [7:0]              i_encoding,
    input  wire  [15:0]             i_payload_ref,
    input  wire  [15:0]             i_payload_size,
    // result channel
    output logic                    o_valid,
    input  wire                     i_ready,
    output logic [1:0]              o_status,
    output logic [ast_pkg::ID_W-1:0] o_subscription_id,
    output logic [15:0]             o_notify_handler,
    output logic [15:0]             o_notify_attr,
    output logic [15:0]             o_notify_trans,
    output logic [7:0]              o_notify_encoding,
    output logic [15:0]             o_notify_ref,
    output logic [15:0]             o_notify_size,
    output logic                    o_expired
);
    import ast_pkg::*;

    t_item      w_item;
    t_ctrl_stat w_stat;
    t_result    w_res;
    logic       w_res_valid;
    logic       w_take;
    logic       w_load;
    t_store_req w_req;
    t_entry     w_rdata;

    // output register
    logic    r_out_valid;
    t_result r_out;

    assign w_item.mode         = i_mode;
    assign w_item.attr_id      = i_attr_id;
    assign w_item.txn_id       = i_txn_id;
    assign w_item.handler      = i_handler;
    assign w_item.encoding     = i_encoding;
    assign w_item.payload_ref  = i_payload_ref;
    assign w_item.payload_size = i_payload_size;

    // Ready whenever the sequencer is idle, even with a result still held.
    assign o_ready = w_stat.idle;
    assign w_take  = i_valid && o_ready;

    // Finished result moves into the output register once it is free.
    assign w_load = w_res_valid && (!r_out_valid || i_ready);

    ast_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (w_take),
        .i_item     (w_item),
        .o_stat     (w_stat),
        .o_res_valid(w_res_valid),
        .o_res      (w_res),
        .i_res_take (w_load),
        .o_req      (w_req),
        .i_rdata    (w_rdata)
    );

    ast_store u_store (
        .i_clk  (i_clk),
        .i_req  (w_req),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_load) begin
            r_out <= w_res;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_status          = r_out.status;
    assign o_subscription_id = r_out.subscription_id;
    assign o_notify_handler  = r_out.notify_handler;
    assign o_notify_attr     = r_out.notify_attr;
    assign o_notify_trans    = r_out.notify_trans;
    assign o_notify_encoding = r_out.notify_encoding;
    assign o_notify_ref      = r_out.notify_ref;
    assign o_notify_size     = r_out.notify_size;
    assign o_expired         = r_out.expired;

    // Checks on the sequencer and result formatting.
    `AST_ASSERT_IMP(a_count_bound, 1'b1, w_stat.count <= CNT_W'(SLOTS), "valid count above SLOTS")
    `AST_ASSERT_NXT(a_busy_after_take, w_take, !o_ready, "took a second item while busy")
    `AST_ASSERT_IMP(a_stored_id, o_valid && (o_status == ST_STORED), o_subscription_id >= ID_BASE, "stored result without slot id")
    `AST_ASSERT_IMP(a_expired_notify, o_valid && o_expired, o_status == ST_NOTIFY, "expiry flag without notification")
    `AST_ASSERT_IMP(a_quiet_fields, o_valid && (o_status != ST_NOTIFY), o_notify_handler == 16'd0 && o_notify_attr == 16'd0, "notify fields set on non-notification")

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

// Tracks the subscription table as the block should hold it and keeps the
// replies it still owes, oldest first.
class subscription_tracker;
    logic [15:0]          key_of [ast_pkg::SLOTS];
    logic [15:0]          handler_of [ast_pkg::SLOTS];
    bit                   one_shot_of [ast_pkg::SLOTS];
    int                   live;
    ast_pkg::t_result     owed [$];
    int                   errors;

    function new();
        live   = 0;
        errors = 0;
    endfunction

    // Only slots below the live count are searched.
    function int find_key(logic [15:0] key);
        for (int i = 0; i < live; i++) begin
            if (key_of[i] == key) return i;
        end
        return -1;
    endfunction

    // Called for every input transfer: update the table, queue the reply.
    function void take_item(ast_pkg::t_item it);
        ast_pkg::t_result r;
        int slot;
        int last;
        r = '0;
        slot = find_key(it.attr_id);
        case (it.mode)
            ast_pkg::MODE_SUB, ast_pkg::MODE_ONCE: begin
                if (slot < 0 && live == ast_pkg::SLOTS) begin
                    r.status = ast_pkg::ST_FULL;
                end else begin
                    if (slot < 0) begin
                        slot = live;
                        live++;
                        key_of[slot] = it.attr_id;
                    end
                    handler_of[slot]  = it.handler;
                    one_shot_of[slot] = (it.mode == ast_pkg::MODE_ONCE);
                    r.status = ast_pkg::ST_STORED;
                    r.subscription_id = ast_pkg::ID_BASE + ast_pkg::ID_W'(slot);
                end
            end
            ast_pkg::MODE_CHANGE: begin
                if (slot < 0) begin
                    r.status = ast_pkg::ST_NONE;
                end else begin
                    r.status          = ast_pkg::ST_NOTIFY;
                    r.notify_handler  = handler_of[slot];
                    r.notify_attr     = it.attr_id;
                    r.notify_trans    = it.txn_id;
                    r.notify_encoding = it.encoding;
                    r.notify_ref      = it.payload_ref;
                    r.notify_size     = it.payload_size;
                    if (one_shot_of[slot]) begin
                        // last live entry fills the hole (no-op if it is the hole)
                        last = live - 1;
                        key_of[slot]      = key_of[last];
                        handler_of[slot]  = handler_of[last];
                        one_shot_of[slot] = one_shot_of[last];
                        live              = last;
                        r.expired         = 1'b1;
                    end
                end
            end
            default: r.status = ast_pkg::ST_NONE;
        endcase
        owed.push_back(r);
    endfunction

    function void diff(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Called for every result transfer.
    function void check_reply(ast_pkg::t_result got);
        ast_pkg::t_result want;
        if (owed.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual status %h id %h",
                     $time, got.status, got.subscription_id);
            errors++;
            return;
        end
        want = owed.pop_front();
        diff("status", 16'(want.status), 16'(got.status));
        diff("subscription_id", 16'(want.subscription_id), 16'(got.subscription_id));
        diff("notify_handler", want.notify_handler, got.notify_handler);
        diff("notify_attr", want.notify_attr, got.notify_attr);
        diff("notify_trans", want.notify_trans, got.notify_trans);
        diff("notify_encoding", 16'(want.notify_encoding), 16'(got.notify_encoding));
        diff("notify_ref", want.notify_ref, got.notify_ref);
        diff("notify_size", want.notify_size, got.notify_size);
        diff("expired", 16'(want.expired), 16'(got.expired));
    endfunction
endclass

module testbench;
    import ast_pkg::*;

    // Mode 3 has no name in the package; it must answer "no subscriber".
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int RESET_CYCLES   = 7;
    localparam int CHOKE_CYCLES   = 300;  // long receiver hold-off
    localparam int CHOKE_PHASE    = 3;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 150;
    // The long receiver hold-off, not the longest item, sets this limit.
    localparam int STALL_LIMIT    = 2000;
    localparam int TAIL_CYCLES    = 40;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [1:0]           i_mode = '0;
    logic [15:0]          i_attr_id = '0;
    logic [15:0]          i_txn_id = '0;
    logic [15:0]          i_handler = '0;
    logic [7:0]           i_encoding = '0;
    logic [15:0]          i_payload_ref = '0;
    logic [15:0]          i_payload_size = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [1:0]           o_status;
    logic [ID_W-1:0]      o_subscription_id;
    logic [15:0]          o_notify_handler;
    logic [15:0]          o_notify_attr;
    logic [15:0]          o_notify_trans;
    logic [7:0]           o_notify_encoding;
    logic [15:0]          o_notify_ref;
    logic [15:0]          o_notify_size;
    logic                 o_expired;

    subscription_tracker  board;
    logic [15:0]          key_pool [$];   // keys in play for the current phase
    bit                   choke_req = 1'b0;
    int                   quiet_cycles = 0;

    attribute_subscription_table uut (.*);

    always #5 i_clk = ~i_clk;

    // Watchdog: any cycle without a transfer on either channel counts.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Offer one item, hold it until the transfer, then idle for a random gap.
    // Valid is only dropped when a gap follows, so back-to-back items keep
    // it high without a same-step low/high pair.
    task automatic push_item(t_item it);
        int gap;
        i_valid        <= 1'b1;
        i_mode         <= it.mode;
        i_attr_id      <= it.attr_id;
        i_txn_id       <= it.txn_id;
        i_handler      <= it.handler;
        i_encoding     <= it.encoding;
        i_payload_ref  <= it.payload_ref;
        i_payload_size <= it.payload_size;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        board.take_item(it);
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_fields(logic [1:0] mode, logic [15:0] attr, logic [15:0] trans,
                               logic [15:0] hnd, logic [7:0] enc, logic [15:0] pref,
                               logic [15:0] psize);
        t_item it;
        it.mode         = mode;
        it.attr_id      = attr;
        it.txn_id       = trans;
        it.handler      = hnd;
        it.encoding     = enc;
        it.payload_ref  = pref;
        it.payload_size = psize;
        push_item(it);
    endtask

    // Sender pause: valid low until every owed reply has come back.
    task automatic drain();
        if (i_valid) i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.owed.size() != 0) @(posedge i_clk);
    endtask

    // Mostly keys from the pool so subscriptions, hits, removals and a full
    // table all happen; a few fully random keys for misses and bit coverage.
    function automatic t_item random_item();
        t_item it;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)      it.mode = MODE_SUB;
        else if (pick < 55) it.mode = MODE_ONCE;
        else if (pick < 96) it.mode = MODE_CHANGE;
        else                it.mode = MODE_UNUSED;
        if ($urandom_range(0, 9) == 0) it.attr_id = 16'($urandom);
        else it.attr_id = key_pool[$urandom_range(0, key_pool.size() - 1)];
        it.txn_id       = 16'($urandom);
        it.handler      = 16'($urandom);
        it.encoding     = 8'($urandom);
        it.payload_ref  = 16'($urandom);
        it.payload_size = 16'($urandom);
        return it;
    endfunction

    // Result side: random ready gaps, plus one long hold-off on request so
    // the block backs up and stalls its input.
    initial begin : result_sink
        t_result got;
        int stall;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = $urandom_range(0, 3);
            if (choke_req) begin
                choke_req = 1'b0;
                i_ready <= 1'b0;
                repeat (CHOKE_CYCLES) @(posedge i_clk);
            end else if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            got.status          = t_status'(o_status);
            got.subscription_id = o_subscription_id;
            got.notify_handler  = o_notify_handler;
            got.notify_attr     = o_notify_attr;
            got.notify_trans    = o_notify_trans;
            got.notify_encoding = o_notify_encoding;
            got.notify_ref      = o_notify_ref;
            got.notify_size     = o_notify_size;
            got.expired         = o_expired;
            board.check_reply(got);
        end
    end

    initial begin : stimulus
        int pool_size [PHASES];
        pool_size = '{6, 18, 40, 12, 24, 3, 30, 16};
        board = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed part ---
        // lookups on an empty table, and the unused mode with all ones
        send_fields(MODE_CHANGE, 16'h0000, 16'h0000, 16'h0000, 8'h00, 16'h0000, 16'h0000);
        send_fields(MODE_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF);
        // extreme keys and handlers
        send_fields(MODE_SUB, 16'h0000, 16'h0000, 16'hFFFF, 8'h00, 16'h0000, 16'h0000);
        send_fields(MODE_SUB, 16'hFFFF, 16'hFFFF, 16'h0000, 8'hFF, 16'hFFFF, 16'hFFFF);
        send_fields(MODE_CHANGE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF);
        // existing key turned one-shot, then fired: slot 1 moves down to slot 0
        send_fields(MODE_ONCE, 16'h0000, 16'h0000, 16'h1234, 8'h00, 16'h0000, 16'h0000);
        send_fields(MODE_CHANGE, 16'h0000, 16'hA5A5, 16'h0000, 8'h5A, 16'h5A5A, 16'hA5A5);
        // removed key must now miss; the moved key still hits
        send_fields(MODE_CHANGE, 16'h0000, 16'h0000, 16'h0000, 8'h00, 16'h0000, 16'h0000);
        send_fields(MODE_CHANGE, 16'hFFFF, 16'h0001, 16'h0000, 8'h01, 16'h0001, 16'h0001);
        // fill the table; the last entry is one-shot
        for (int i = 1; i < SLOTS; i++) begin
            send_fields((i == SLOTS - 1) ? MODE_ONCE : MODE_SUB, 16'h0100 + 16'(i),
                        16'($urandom), 16'($urandom), 8'($urandom), 16'($urandom),
                        16'($urandom));
        end
        // table full for a new key, overwrite still works
        send_fields(MODE_SUB, 16'h0200, 16'h0000, 16'h7777, 8'h00, 16'h0000, 16'h0000);
        send_fields(MODE_ONCE, 16'h0101, 16'h0000, 16'h8888, 8'h00, 16'h0000, 16'h0000);
        // one-shot in the last slot is just dropped
        send_fields(MODE_CHANGE, 16'h0100 + 16'(SLOTS - 1), 16'h1111, 16'h0000, 8'h22,
                    16'h3333, 16'h4444);
        // one-shot in the middle pulls the last entry into its slot
        send_fields(MODE_CHANGE, 16'h0101, 16'h5555, 16'h0000, 8'h66, 16'h7777, 16'h8888);
        drain();

        // --- random part, a fresh key pool per phase ---
        for (int phase = 0; phase < PHASES; phase++) begin
            key_pool.delete();
            for (int k = 0; k < pool_size[phase]; k++) key_pool.push_back(16'($urandom));
            if (phase == CHOKE_PHASE) choke_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) push_item(random_item());
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.owed.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+sv
sv/ast_pkg.sv
sv/ast_store.sv
sv/ast_ctrl.sv
sv/attribute_subscription_table.sv
tb/testbench.sv
